[rtl/core/fpk_pkg.sv]
// fpk_pkg: shared types and constants for the float pack/unpack pipeline
// no dependencies
package fpk_pkg;

  typedef enum logic [1:0] {
    FMT_HALF   = 2'd0,
    FMT_SINGLE = 2'd1,
    FMT_DOUBLE = 2'd2
  } fmt_e;

  typedef enum logic {
    CMD_PACK   = 1'b0,
    CMD_UNPACK = 1'b1
  } cmd_e;

  localparam logic [10:0] DExpOnes = 11'h7ff;
  localparam logic signed [12:0] DBias = 13'sd1023;

  // stage 1 to stage 2
  typedef struct packed {
    logic        done;   // result already final
    logic [63:0] res;
    logic        err;
    logic        sign;
    logic [1:0]  fmt;
    logic        subn;
    logic [5:0]  lz;
    logic [10:0] ef;
    logic [51:0] m;
  } s1_t;

  // stage 2 to stage 3
  typedef struct packed {
    logic               done;
    logic [63:0]        res;
    logic               err;
    logic               sign;
    logic [1:0]         fmt;
    logic signed [12:0] e;
    logic [51:0]        m;
  } s2_t;

  // saturated largest magnitude with sign kept
  function automatic logic [63:0] sat_word(input logic [1:0] fmt, input logic sign);
    logic [63:0] w;
    w = '0;
    case (fmt_e'(fmt))
      FMT_HALF:   w = {48'd0, sign, 15'h7fff};
      FMT_SINGLE: w = {32'd0, sign, 31'h7fff_ffff};
      FMT_DOUBLE: w = {sign, 63'h7fff_ffff_ffff_ffff};
      default:    w = '0;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/fpk_classify.sv]
// fpk_classify: first stage, decodes the item, finishes unpack and special
// cases, and finds the leading zero count of subnormal fractions; uses fpk_pkg
module fpk_classify (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic            command_i,
  input  logic [1:0]      format_i,
  input  logic [63:0]     value_i,
  output logic            valid_o,
  output fpk_pkg::s1_t    data_o
);

  fpk_pkg::s1_t s1_d, s1_q;
  logic         valid_q;
  logic [10:0]  ef;
  logic [10:0]  ue;
  logic [5:0]   lz;

  assign ef = value_i[62:52];

  always_comb begin
    lz = '0;
    for (int i = 0; i < 52; i++) begin
      if (value_i[i]) lz = 6'(51 - i);
    end
  end

  always_comb begin
    s1_d      = '0;
    s1_d.sign = value_i[63];
    s1_d.fmt  = format_i;
    s1_d.ef   = ef;
    s1_d.m    = value_i[51:0];
    s1_d.lz   = lz;
    s1_d.subn = (ef == 11'd0);
    ue        = '0;
    if (format_i != fpk_pkg::FMT_HALF && format_i != fpk_pkg::FMT_SINGLE &&
        format_i != fpk_pkg::FMT_DOUBLE) begin
      s1_d.done = 1'b1;
      s1_d.err  = 1'b1;
    end else if (fpk_pkg::cmd_e'(command_i) == fpk_pkg::CMD_PACK) begin
      if (value_i[62:0] == 63'd0) begin
        s1_d.done = 1'b1;
      end else if (ef == fpk_pkg::DExpOnes) begin
        s1_d.done = 1'b1;
        s1_d.err  = 1'b1;
        s1_d.res  = fpk_pkg::sat_word(format_i, value_i[63]);
      end
    end else begin
      s1_d.done = 1'b1;
      case (fpk_pkg::fmt_e'(format_i))
        fpk_pkg::FMT_HALF: begin
          ue = 11'({6'd0, value_i[14:10]} + 11'd1008);
          if (value_i[15:0] != 16'd0)
            s1_d.res = {value_i[15], ue, value_i[9:0], 42'd0};
        end
        fpk_pkg::FMT_SINGLE: begin
          ue = 11'({3'd0, value_i[30:23]} + 11'd896);
          if (value_i[31:0] != 32'd0)
            s1_d.res = {value_i[31], ue, value_i[22:0], 29'd0};
        end
        fpk_pkg::FMT_DOUBLE: begin
          s1_d.res = value_i;
          s1_d.err = (value_i != 64'd0) && (ef == 11'd0 || ef == fpk_pkg::DExpOnes);
        end
        default: s1_d.err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = s1_q;

endmodule

[rtl/core/fpk_norm.sv]
// fpk_norm: second stage, normalizes subnormal fractions and forms the
// unbiased exponent; uses fpk_pkg
module fpk_norm (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  fpk_pkg::s1_t data_i,
  output logic         valid_o,
  output fpk_pkg::s2_t data_o
);

  fpk_pkg::s2_t s2_d, s2_q;
  logic         valid_q;
  logic [6:0]   shamt;

  assign shamt = {1'b0, data_i.lz} + 7'd1;

  always_comb begin
    s2_d      = '0;
    s2_d.done = data_i.done;
    s2_d.res  = data_i.res;
    s2_d.err  = data_i.err;
    s2_d.sign = data_i.sign;
    s2_d.fmt  = data_i.fmt;
    if (data_i.subn) begin
      s2_d.e = -fpk_pkg::DBias - $signed({7'd0, data_i.lz});
      s2_d.m = data_i.m << shamt;
    end else begin
      s2_d.e = $signed({2'd0, data_i.ef}) - fpk_pkg::DBias;
      s2_d.m = data_i.m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = s2_q;

endmodule

[rtl/core/fpk_round.sv]
// fpk_round: third stage, rounds the fraction, rebiases, checks range and
// assembles the packed word into the output register; uses fpk_pkg
module fpk_round (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  fpk_pkg::s2_t data_i,
  output logic         valid_o,
  output logic [63:0]  result_o,
  output logic         range_error_o
);

  logic               valid_q;
  logic [63:0]        res_d, res_q;
  logic               err_d, err_q;
  logic [53:0]        acc;
  logic [52:0]        sig;
  logic               carry;
  logic signed [12:0] bias, biased;
  logic [12:0]        emax;

  always_comb begin
    acc   = '0;
    sig   = '0;
    carry = 1'b0;
    bias  = '0;
    emax  = '0;
    // floor(frac * (2^n + 1/2)): add the half-weighted term, keep its carry
    case (fpk_pkg::fmt_e'(data_i.fmt))
      fpk_pkg::FMT_HALF: begin
        acc   = {1'b0, data_i.m[41:0], 11'd0} + {2'd0, data_i.m};
        sig   = {43'd0, data_i.m[51:42]} + {52'd0, acc[53]};
        carry = sig[10];
        bias  = 13'sd15;
        emax  = 13'd31;
      end
      fpk_pkg::FMT_SINGLE: begin
        acc   = {1'b0, data_i.m[28:0], 24'd0} + {2'd0, data_i.m};
        sig   = {30'd0, data_i.m[51:29]} + {52'd0, acc[53]};
        carry = sig[23];
        bias  = 13'sd127;
        emax  = 13'd255;
      end
      fpk_pkg::FMT_DOUBLE: begin
        sig  = {1'b0, data_i.m};
        bias = fpk_pkg::DBias;
        emax = 13'd2047;
      end
      default: ;
    endcase
    biased = data_i.e + bias + $signed({12'd0, carry});
  end

  always_comb begin
    res_d = data_i.res;
    err_d = data_i.err;
    if (!data_i.done) begin
      err_d = 1'b0;
      if (biased < 0) begin
        res_d = '0;
        err_d = 1'b1;
      end else if ($unsigned(biased) > emax) begin
        res_d = fpk_pkg::sat_word(data_i.fmt, data_i.sign);
        err_d = 1'b1;
      end else begin
        case (fpk_pkg::fmt_e'(data_i.fmt))
          fpk_pkg::FMT_HALF:
            res_d = {48'd0, data_i.sign, biased[4:0], carry ? 10'd0 : sig[9:0]};
          fpk_pkg::FMT_SINGLE:
            res_d = {32'd0, data_i.sign, biased[7:0], carry ? 23'd0 : sig[22:0]};
          fpk_pkg::FMT_DOUBLE:
            res_d = {data_i.sign, biased[10:0], sig[51:0]};
          default: res_d = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign valid_o       = valid_q;
  assign result_o      = res_q;
  assign range_error_o = err_q;

endmodule

[rtl/core/float_format_pack_unpack_top.sv]
// path: an accepted input passes the classify, normalize and round registers to result valid
// throughput: one item per cycle; classify, normalize and round stages
// advance together and all hold while the output is stalled
// reset: asynchronous active low, clears stage valid bits only
// top level of the float pack/unpack converter
// uses fpk_pkg, fpk_classify, fpk_norm, fpk_round
module float_format_pack_unpack_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [1:0]  format_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        range_error_o
);

  logic         adv;
  logic         v1, v2;
  fpk_pkg::s1_t d1;
  fpk_pkg::s2_t d2;

  // whole pipe moves unless a finished result is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  fpk_classify u_cls (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i),
    .command_i, .format_i, .value_i, .valid_o(v1), .data_o(d1)
  );

  fpk_norm u_nrm (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1), .data_i(d1),
    .valid_o(v2), .data_o(d2)
  );

  fpk_round u_rnd (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2), .data_i(d2),
    .valid_o(out_valid_o), .result_o, .range_error_o
  );

endmodule

[rtl/core/fpk_checker.sv]
// fpk_checker: port-level checks for the float pack/unpack converter
// bound to float_format_pack_unpack_top
module fpk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_o,
  input logic        range_error_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !in_stall_o ##1 !in_stall_o |=> out_valid_o)
    else $error("accepted item did not reach the output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_o) && $stable(range_error_o)))
    else $error("stalled result changed");

endmodule

bind float_format_pack_unpack_top fpk_checker u_fpk_checker (.*);

[tb/float_format_pack_unpack_checker.sv]
// checker for the float pack/unpack converter: watches both channels,
// predicts each result and compares it; uses fpk_pkg
`timescale 1ns / 100ps
module float_format_pack_unpack_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        command_i,
  input  logic [1:0]  format_i,
  input  logic [63:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] result_i,
  input  logic        range_error_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [63:0] res;
    logic        err;
  } conv_t;

  conv_t expected_q[$];

  function automatic conv_t pack_value(logic [63:0] x, int bits, int kb);
    conv_t o;
    int n, sh, e, biased, p;
    logic [63:0] m, sat, emax, q, r, sig;
    logic [10:0] ef;
    logic sign;
    n = bits - kb - 1;
    sign = x[63];
    ef = x[62:52];
    m = {12'd0, x[51:0]};
    emax = (64'd1 << kb) - 1;
    sat = (64'(sign) << (bits - 1)) | (emax << n) | ((64'd1 << n) - 1);
    o.err = 0;
    o.res = 0;
    if (x[62:0] == 0) return o;
    if (ef == fpk_pkg::DExpOnes) begin
      o.err = 1;
      o.res = sat;
      return o;
    end
    if (ef == 0) begin
      p = 51;
      while (m[p] == 0 && p > 0) p--;
      e = -1022 - (52 - p);
      m = (m << (52 - p)) & ((64'd1 << 52) - 1);
    end else begin
      e = int'(ef) - 1023;
    end
    sh = 52 - n;
    q = m >> sh;
    r = m & ((64'd1 << sh) - 1);
    sig = q + ((((r << (n + 1)) + m) >> 53) & 64'd1);
    if ((sig >> n) != 0) begin
      sig = 0;
      e++;
    end
    biased = e + (1 << (kb - 1)) - 1;
    if (biased < 0) begin
      o.err = 1;
      return o;
    end
    if (biased > int'(emax)) begin
      o.err = 1;
      o.res = sat;
      return o;
    end
    o.res = (64'(sign) << (bits - 1)) | (64'(biased) << n) | sig;
    return o;
  endfunction

  function automatic conv_t unpack_value(logic [63:0] x, int bits, int kb);
    conv_t o;
    int n, e;
    logic [63:0] w, emax, ef, fr;
    n = bits - kb - 1;
    w = (bits >= 64) ? x : (x & ((64'd1 << bits) - 1));
    emax = (64'd1 << kb) - 1;
    o.err = 0;
    o.res = 0;
    if (w == 0) return o;
    ef = (w >> n) & emax;
    fr = w & ((64'd1 << n) - 1);
    if (bits >= 64) begin
      o.err = (ef == 0 || ef == emax);
      o.res = w;
      return o;
    end
    e = int'(ef) - ((1 << (kb - 1)) - 1) + 1023;
    o.res = (64'(w[bits - 1]) << 63) | (64'(e) << 52) | (fr << (52 - n));
    return o;
  endfunction

  function automatic conv_t convert(logic cmd, logic [1:0] fmt, logic [63:0] v);
    conv_t o;
    int bits, kb;
    o.res = 0;
    o.err = 1;
    case (fmt)
      fpk_pkg::FMT_HALF:   begin bits = 16; kb = 5; end
      fpk_pkg::FMT_SINGLE: begin bits = 32; kb = 8; end
      fpk_pkg::FMT_DOUBLE: begin bits = 64; kb = 11; end
      default:             return o;
    endcase
    if (cmd == fpk_pkg::CMD_PACK) return pack_value(v, bits, kb);
    return unpack_value(v, bits, kb);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_t exp_c;
    int bad;
    if (!rst_ni) begin
      errors_o  <= 0;
      pending_o <= 0;
      expected_q.delete();
    end else begin
      bad = 0;
      if (in_valid_i && !in_stall_i) expected_q.push_back(convert(command_i, format_i, value_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transfer result=%h err=%b", $time, result_i, range_error_i);
          bad++;
        end else begin
          exp_c = expected_q.pop_front();
          if (exp_c.res !== result_i) begin
            $display("%0t: result expected %h actual %h", $time, exp_c.res, result_i);
            bad++;
          end
          if (exp_c.err !== range_error_i) begin
            $display("%0t: range_error expected %b actual %b", $time, exp_c.err,
                     range_error_i);
            bad++;
          end
        end
      end
      errors_o  <= errors_o + bad;
      pending_o <= expected_q.size();
    end
  end

endmodule

[tb/float_format_pack_unpack_top_tb.sv]
// stimulus and verdict for the float pack/unpack converter
// uses fpk_pkg, float_format_pack_unpack_top and float_format_pack_unpack_checker
`timescale 1ns / 100ps
module float_format_pack_unpack_top_tb;

  localparam int NumRandom = 750;
  localparam int CycleLimit = 200000;
  // format code with no defined format
  localparam logic [1:0] FmtBad = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [1:0]  format_i;
  logic [63:0] value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_o;
  logic        range_error_o;
  int          errors;
  int          pending;
  int          cycles;
  int          sent;
  bit          hold_off;

  float_format_pack_unpack_top dut (.*);

  float_format_pack_unpack_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .format_i,
    .value_i, .out_valid_i(out_valid_o), .out_stall_i, .result_i(result_o),
    .range_error_i(range_error_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stall per transfer while sent is 300 to 600, one long hold-off
  initial begin
    int w;
    out_stall_i = 1;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1;
        repeat (60) @(posedge clk_i);
        hold_off = 0;
      end
      w = $urandom_range(0, 3);
      if (sent < 300 || sent > 600) w = 0;
      if (w > 0) begin
        out_stall_i <= 1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_item(logic cmd, logic [1:0] fmt, logic [63:0] v);
    int w;
    w = (sent < 150 || sent > 450) ? $urandom_range(0, 3) : 0;
    if (w > 0) begin
      in_valid_i <= 0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1;
    command_i  <= cmd;
    format_i   <= fmt;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    logic [10:0] e;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: e = 0;
      1: e = 11'h7ff;
      2: e = 11'd1023 + 11'($urandom_range(0, 40)) - 11'd20;
      3: e = 11'd1023 + 11'($urandom_range(0, 300)) - 11'd150;
      4: e = 11'd1023 + 11'($urandom_range(0, 2200)) - 11'd1100;
      5: begin
        e = 11'd1023 + 11'($urandom_range(0, 40)) - 11'd20;
        v[51:20] = '1;
        v[51:0] = v[51:0] | {52{$urandom_range(0, 1) == 1}};
      end
      default: e = v[62:52];
    endcase
    v[62:52] = e;
    return v;
  endfunction

  initial begin
    logic [63:0] v;
    logic [1:0]  f;
    rst_ni = 0;
    in_valid_i = 0;
    command_i = fpk_pkg::CMD_PACK;
    format_i = fpk_pkg::FMT_HALF;
    value_i = 0;
    sent = 0;
    hold_off = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: zeros, one, infinities, nan, subnormals, rounding carry, ranges
    for (int fi = 0; fi < 3; fi++) begin
      f = fpk_pkg::fmt_e'(fi);
      send_item(fpk_pkg::CMD_PACK, f, 64'h0);
      send_item(fpk_pkg::CMD_PACK, f, 64'h8000_0000_0000_0000);
      send_item(fpk_pkg::CMD_PACK, f, 64'h3ff0_0000_0000_0000);
      send_item(fpk_pkg::CMD_PACK, f, 64'hfff0_0000_0000_0000);
      send_item(fpk_pkg::CMD_PACK, f, 64'h7fff_ffff_ffff_ffff);
      send_item(fpk_pkg::CMD_PACK, f, 64'h0000_0000_0000_0001);
      send_item(fpk_pkg::CMD_PACK, f, 64'h3fff_ffff_ffff_ffff);
      send_item(fpk_pkg::CMD_PACK, f, 64'hc7ef_ffff_ffff_ffff);
      send_item(fpk_pkg::CMD_UNPACK, f, 64'h0);
      send_item(fpk_pkg::CMD_UNPACK, f, 64'hffff_ffff_ffff_ffff);
    end
    send_item(fpk_pkg::CMD_PACK, FmtBad, 64'h3ff0_0000_0000_0000);
    send_item(fpk_pkg::CMD_UNPACK, FmtBad, 64'h1234);
    send_item(fpk_pkg::CMD_UNPACK, fpk_pkg::FMT_DOUBLE, 64'h0000_0000_0000_0005);
    send_item(fpk_pkg::CMD_UNPACK, fpk_pkg::FMT_HALF, 64'hffff_ffff_ffff_0000);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 200) hold_off = 1;
      f = ($urandom_range(0, 30) == 0) ? FmtBad : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 0) begin
        send_item(fpk_pkg::CMD_PACK, f, rand_double());
      end else begin
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) v = v & 64'hffff;
        send_item(fpk_pkg::CMD_UNPACK, f, v);
      end
    end
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending != 0) begin
      $display("%0t: %0d results still outstanding at end of run", $time, pending);
    end
    $display("covered %0d conversions: pack and unpack in all formats, zeros, inf/nan,", sent);
    $display("subnormals, rounding carry, overflow, underflow and a bad format code");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
